@@ rtl/core/gts_pkg.sv @@
// Package for the traffic green time splitter.
// Holds the sequencer state type, register indexes and fixed widths.
// No dependencies.
`default_nettype none

package gts_pkg;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WDIV,
      ST_SHMUL,
      ST_SHDIV,
      ST_DONOR,
      ST_CUTMUL,
      ST_CUTDIV,
      ST_GREEN,
      ST_SORT,
      ST_DIST,
      ST_CLAMP,
      ST_FINISH
   } state_type;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_TIME  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOST_TIME   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_GREEN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_GREEN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHARE_SCALE = 3'd4;

   // fixed widths
   localparam int EFF_W   = 8;   // effective time, seconds
   localparam int SHARE_W = 24;  // share, Q8.16 (minimum weight may exceed 1.0)
   localparam int DEF_W   = 26;  // deficit, up to three shares
   localparam int FRAC_W  = 16;
   localparam int GREEN_W = 17;  // integer green before clamp

   // floor(x/3) for x < 512 as (x*171) >> 9
   localparam logic [8:0] RECIP3       = 9'd171;
   localparam int         RECIP3_SHIFT = 9;

   // reset values of the registers
   localparam logic [7:0]  RST_CYCLE_TIME  = 8'd120;
   localparam logic [3:0]  RST_LOST_TIME   = 4'd4;
   localparam logic [7:0]  RST_MIN_GREEN   = 8'd10;
   localparam logic [7:0]  RST_MAX_GREEN   = 8'd80;
   localparam logic [15:0] RST_SHARE_SCALE = 16'd58982;

endpackage

`default_nettype wire

@@ rtl/core/gts_div.sv @@
// Restoring divider for the green time splitter, one quotient bit per cycle.
// Standalone; no package dependency.
`default_nettype none

module gts_div #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;
   logic             fits;

   // one trial subtraction per cycle; quotient bits shift into num
   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      fits    = !diff[DEN_W];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

`default_nettype wire

@@ rtl/core/traffic_green_time_splitter.sv @@
// Top level of the traffic green time splitter: sequencer, registers, output stage.
// Depends on gts_pkg and gts_div.
//
//   channel  | ports                           | direction
//   req      | req_valid/req_stall, count_a..c | in  (one beat per signal cycle)
//   rsp      | rsp_valid/rsp_stall, green_a..c | out (one beat per req beat)
//   csr      | csr_write_en/index/data         | in  (write only)
//
// First-cycle and zero-total items skip the divider; others make up to six
// passes through the single bit-serial divider. req_stall is high while an
// item is in work. Reset is synchronous; it restores the register defaults and
// marks the first cycle pending. A stalled rsp beat holds while the next item works.
`default_nettype none

module traffic_green_time_splitter
   import gts_pkg::*;
#(
   parameter int COUNT_WIDTH = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [COUNT_WIDTH-1:0] req_count_a,
   input  wire logic [COUNT_WIDTH-1:0] req_count_b,
   input  wire logic [COUNT_WIDTH-1:0] req_count_c,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_green_a,
   output logic [7:0]                  rsp_green_b,
   output logic [7:0]                  rsp_green_c,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SUM_W = COUNT_WIDTH + 2;
   localparam int DEN_W = (SUM_W > EFF_W) ? SUM_W : EFF_W;
   localparam int NUM_W = DEF_W + COUNT_WIDTH;

   // configuration
   logic [7:0]  cycle_time_ff, lost_time_pad;
   logic [3:0]  lost_time_ff;
   logic [7:0]  min_green_ff, max_green_ff;
   logic [15:0] share_scale_ff;

   // control
   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic       first_done_ff, first_done_in;
   logic       issue_ff, issue_in;
   logic       clamp_en_ff, clamp_en_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // working data
   logic [COUNT_WIDTH-1:0] cnt_ff [3];
   logic [COUNT_WIDTH-1:0] cnt_in [3];
   logic [EFF_W-1:0]       eff_ff, eff_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SUM_W-1:0]       donors_ff, donors_in;
   logic [SHARE_W-1:0]     w_ff, w_in;
   logic [SHARE_W-1:0]     share_ff [3];
   logic [SHARE_W-1:0]     share_in [3];
   logic [DEF_W-1:0]       def_ff, def_in;
   logic [2:0]             donor_ff, donor_in;
   logic [NUM_W-1:0]       prod_ff, prod_in;
   logic [GREEN_W-1:0]     g_ff [3];
   logic [GREEN_W-1:0]     g_in [3];
   logic [FRAC_W-1:0]      frac_ff [3];
   logic [FRAC_W-1:0]      frac_in [3];
   logic [1:0]             ord_ff [3];
   logic [1:0]             ord_in [3];
   logic [EFF_W-1:0]       left_ff, left_in;
   logic [7:0]             green_ff [3];
   logic [7:0]             green_in [3];

   // divider hookup
   logic             div_start, div_done;
   logic [NUM_W-1:0] div_num, div_quo;
   logic [DEN_W-1:0] div_den;

   // scratch
   logic [5:0]           three_lost;
   logic [EFF_W-1:0]     eff_calc;
   logic [SUM_W-1:0]     sum_calc;
   logic [16:0]          recip_prod;
   logic [16:0]          left_prod;
   logic [EFF_W-1:0]     each;
   logic [SHARE_W-1:0]   q_share;
   logic [DEF_W-1:0]     cut;
   logic [31:0]          e_prod;
   logic [GREEN_W:0]     used;
   logic [1:0]           ord_t [3];
   logic [1:0]           swap_t;
   logic [EFF_W-1:0]     left_q;
   logic [1:0]           left_r;
   logic [SUM_W-1:0]     donor_sum;
   logic                 last_idx;

   assign lost_time_pad = {4'd0, lost_time_ff};

   // effective time, item sum, E/3
   always_comb begin
      three_lost = 6'(lost_time_pad * 8'd3);
      eff_calc   = ({2'd0, three_lost} > cycle_time_ff) ? '0
                   : cycle_time_ff - {2'd0, three_lost};
      sum_calc   = SUM_W'(req_count_a) + SUM_W'(req_count_b) + SUM_W'(req_count_c);
      recip_prod = 17'(eff_calc * RECIP3);
      each       = EFF_W'(recip_prod >> RECIP3_SHIFT);
   end

   // divider operand select
   always_comb begin
      div_start = issue_ff;
      div_num   = prod_ff;
      case (state_ff)
         ST_WDIV:   div_den = DEN_W'(eff_ff);
         ST_SHDIV:  div_den = DEN_W'(sum_ff);
         ST_CUTDIV: div_den = DEN_W'(donors_ff);
         default:   div_den = DEN_W'(sum_ff);
      endcase
   end

   gts_div #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // sequencer: next state and working data
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      first_done_in = first_done_ff;
      issue_in      = 1'b0;
      clamp_en_in   = clamp_en_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cnt_in        = cnt_ff;
      eff_in        = eff_ff;
      sum_in        = sum_ff;
      donors_in     = donors_ff;
      w_in          = w_ff;
      share_in      = share_ff;
      def_in        = def_ff;
      donor_in      = donor_ff;
      prod_in       = prod_ff;
      g_in          = g_ff;
      frac_in       = frac_ff;
      ord_in        = ord_ff;
      left_in       = left_ff;
      green_in      = green_ff;
      last_idx      = (idx_ff == 2'd2);
      q_share       = div_quo[SHARE_W-1:0];
      cut           = div_quo[DEF_W-1:0];
      e_prod        = 32'(share_ff[idx_ff] * eff_ff);
      used          = '0;
      ord_t         = ord_ff;
      swap_t        = '0;
      left_prod     = '0;
      left_q        = '0;
      left_r        = '0;
      donor_sum     = '0;
      req_stall     = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in[0]     = req_count_a;
               cnt_in[1]     = req_count_b;
               cnt_in[2]     = req_count_c;
               eff_in        = eff_calc;
               sum_in        = sum_calc;
               first_done_in = 1'b1;
               idx_in        = '0;
               def_in        = '0;
               w_in          = '0;
               if (!first_done_ff || sum_calc == '0) begin
                  // equal split; unclamped on the first cycle
                  for (int i = 0; i < 3; i++) g_in[i] = GREEN_W'(each);
                  clamp_en_in = first_done_ff;
                  state_in    = ST_CLAMP;
               end else begin
                  clamp_en_in = 1'b1;
                  if (eff_calc == '0) begin
                     state_in = ST_SHMUL;
                  end else begin
                     prod_in  = NUM_W'({min_green_ff, 16'd0});
                     issue_in = 1'b1;
                     state_in = ST_WDIV;
                  end
               end
            end
         end
         ST_WDIV: begin
            if (div_done) begin
               w_in     = div_quo[SHARE_W-1:0];
               state_in = ST_SHMUL;
            end
         end
         ST_SHMUL: begin
            prod_in  = NUM_W'(cnt_ff[idx_ff] * share_scale_ff);
            issue_in = 1'b1;
            state_in = ST_SHDIV;
         end
         ST_SHDIV: begin
            if (div_done) begin
               // raise a share below the weight, collect the deficit
               if (q_share < w_ff) begin
                  def_in           = def_ff + DEF_W'(w_ff - q_share);
                  share_in[idx_ff] = w_ff;
               end else begin
                  share_in[idx_ff] = q_share;
               end
               idx_in   = last_idx ? 2'd0 : idx_ff + 2'd1;
               state_in = last_idx ? ST_DONOR : ST_SHMUL;
            end
         end
         ST_DONOR: begin
            for (int i = 0; i < 3; i++) begin
               donor_in[i] = share_ff[i] > w_ff;
               if (donor_in[i]) donor_sum = donor_sum + SUM_W'(cnt_ff[i]);
            end
            donors_in = donor_sum;
            idx_in    = '0;
            state_in  = (def_ff != '0 && donor_sum != '0) ? ST_CUTMUL : ST_GREEN;
         end
         ST_CUTMUL: begin
            if (donor_ff[idx_ff]) begin
               prod_in  = NUM_W'(def_ff * cnt_ff[idx_ff]);
               issue_in = 1'b1;
               state_in = ST_CUTDIV;
            end else begin
               idx_in   = last_idx ? 2'd0 : idx_ff + 2'd1;
               state_in = last_idx ? ST_GREEN : ST_CUTMUL;
            end
         end
         ST_CUTDIV: begin
            if (div_done) begin
               // take the donor's part, saturate at zero
               share_in[idx_ff] = (cut > DEF_W'(share_ff[idx_ff])) ? '0
                                  : share_ff[idx_ff] - SHARE_W'(cut);
               idx_in   = last_idx ? 2'd0 : idx_ff + 2'd1;
               state_in = last_idx ? ST_GREEN : ST_CUTMUL;
            end
         end
         ST_GREEN: begin
            g_in[idx_ff]    = GREEN_W'(e_prod[31:16]);
            frac_in[idx_ff] = e_prod[15:0];
            idx_in          = last_idx ? 2'd0 : idx_ff + 2'd1;
            state_in        = last_idx ? ST_SORT : ST_GREEN;
         end
         ST_SORT: begin
            // exchange pass on fractions, largest first; strict compare, a tied pair is not swapped
            ord_t[0] = 2'd0;
            ord_t[1] = 2'd1;
            ord_t[2] = 2'd2;
            if (frac_ff[ord_t[1]] > frac_ff[ord_t[0]]) begin
               swap_t = ord_t[0]; ord_t[0] = ord_t[1]; ord_t[1] = swap_t;
            end
            if (frac_ff[ord_t[2]] > frac_ff[ord_t[0]]) begin
               swap_t = ord_t[0]; ord_t[0] = ord_t[2]; ord_t[2] = swap_t;
            end
            if (frac_ff[ord_t[2]] > frac_ff[ord_t[1]]) begin
               swap_t = ord_t[1]; ord_t[1] = ord_t[2]; ord_t[2] = swap_t;
            end
            ord_in   = ord_t;
            used     = (GREEN_W+1)'(g_ff[0]) + (GREEN_W+1)'(g_ff[1])
                       + (GREEN_W+1)'(g_ff[2]);
            left_in  = ((GREEN_W+1)'(eff_ff) > used) ? eff_ff - EFF_W'(used) : '0;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            // hand out leftover seconds round-robin in fraction order
            left_prod = 17'(left_ff * RECIP3);
            left_q    = EFF_W'(left_prod >> RECIP3_SHIFT);
            left_r    = 2'(left_ff - EFF_W'(left_q * 8'd3));
            for (int k = 0; k < 3; k++) begin
               g_in[ord_ff[k]] = g_ff[ord_ff[k]] + GREEN_W'(left_q)
                                 + GREEN_W'((2'(k) < left_r) ? 1'b1 : 1'b0);
            end
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            for (int i = 0; i < 3; i++) begin
               if (!clamp_en_ff)
                  green_in[i] = g_ff[i][7:0];
               else if (g_ff[i] < GREEN_W'(min_green_ff))
                  green_in[i] = min_green_ff;
               else if (g_ff[i] > GREEN_W'(max_green_ff))
                  green_in[i] = max_green_ff;
               else
                  green_in[i] = g_ff[i][7:0];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         first_done_ff  <= 1'b0;
         issue_ff       <= 1'b0;
         clamp_en_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         cycle_time_ff  <= RST_CYCLE_TIME;
         lost_time_ff   <= RST_LOST_TIME;
         min_green_ff   <= RST_MIN_GREEN;
         max_green_ff   <= RST_MAX_GREEN;
         share_scale_ff <= RST_SHARE_SCALE;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         first_done_ff <= first_done_in;
         issue_ff      <= issue_in;
         clamp_en_ff   <= clamp_en_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_CYCLE_TIME:  cycle_time_ff  <= csr_data[7:0];
               CSR_LOST_TIME:   lost_time_ff   <= csr_data[3:0];
               CSR_MIN_GREEN:   min_green_ff   <= csr_data[7:0];
               CSR_MAX_GREEN:   max_green_ff   <= csr_data[7:0];
               CSR_SHARE_SCALE: share_scale_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // working data and output beat
   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      eff_ff    <= eff_in;
      sum_ff    <= sum_in;
      donors_ff <= donors_in;
      w_ff      <= w_in;
      share_ff  <= share_in;
      def_ff    <= def_in;
      donor_ff  <= donor_in;
      prod_ff   <= prod_in;
      g_ff      <= g_in;
      frac_ff   <= frac_in;
      ord_ff    <= ord_in;
      left_ff   <= left_in;
      green_ff  <= green_in;
      if (state_ff == ST_FINISH && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_green_a <= green_ff[0];
         rsp_green_b <= green_ff[1];
         rsp_green_c <= green_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   a_div_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_den != '0)
      else $error("divider started with zero divisor");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != ST_IDLE)
      else $error("item accepted but sequencer stayed idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result beat raised outside finish");

   a_issue_only_in_div: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> (state_ff == ST_WDIV || state_ff == ST_SHDIV
                    || state_ff == ST_CUTDIV))
      else $error("divider start outside a divide state");

endmodule

`default_nettype wire

@@ dv/traffic_green_time_splitter_tb.sv @@
// Testbench for traffic_green_time_splitter: random and directed lane counts with
// a scoreboard that predicts the three green durations. Depends on gts_pkg and the RTL.
`default_nettype none

module traffic_green_time_splitter_tb
   import gts_pkg::*;
;

   typedef struct {
      logic [7:0] ga, gb, gc;
   } green_set_type;

   // predicts green splits and checks rsp beats in order
   class green_scoreboard;
      int unsigned cyc_time, lost, gmin, gmax, scale;
      bit first_done;
      green_set_type pending[$];
      int mismatches;
      int checked;

      function void restore();
         cyc_time = 120; lost = 4; gmin = 10; gmax = 80; scale = 58982;
         first_done = 0;
         pending.delete();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
         case (idx)
            CSR_CYCLE_TIME:  cyc_time = val[7:0];
            CSR_LOST_TIME:   lost = val[3:0];
            CSR_MIN_GREEN:   gmin = val[7:0];
            CSR_MAX_GREEN:   gmax = val[7:0];
            CSR_SHARE_SCALE: scale = val;
            default: ;
         endcase
      endfunction

      function longint clamp(longint x);
         if (x < gmin) return gmin;
         if (x > gmax) return gmax;
         return x;
      endfunction

      // print one mismatch line and count it
      task report_error(string msg);
         mismatches++;
         $display("mismatch @%0t: %s", $realtime, msg);
      endtask

      // compute the split for one beat of counts
      function void note_counts(logic [9:0] ca, logic [9:0] cb, logic [9:0] cc);
         longint cnt[3], shr[3], g[3], frc[3];
         longint eff, total, wmin, deficit, donors, used, left, cut, e;
         int ord[3];
         int t;
         bit first;
         green_set_type r;
         cnt[0] = ca; cnt[1] = cb; cnt[2] = cc;
         ord[0] = 0; ord[1] = 1; ord[2] = 2;
         deficit = 0; donors = 0; used = 0;
         first = !first_done;
         first_done = 1;
         eff = (3 * lost > cyc_time) ? 0 : cyc_time - 3 * lost;
         total = cnt[0] + cnt[1] + cnt[2];
         if (first || total == 0) begin
            for (int i = 0; i < 3; i++) g[i] = first ? eff / 3 : clamp(eff / 3);
         end else begin
            wmin = (eff == 0) ? 0 : (longint'(gmin) << 16) / eff;
            for (int i = 0; i < 3; i++) begin
               shr[i] = cnt[i] * scale / total;
               if (shr[i] < wmin) begin
                  deficit += wmin - shr[i];
                  shr[i] = wmin;
               end
            end
            if (deficit > 0) begin
               for (int i = 0; i < 3; i++) if (shr[i] > wmin) donors += cnt[i];
               if (donors > 0) begin
                  for (int i = 0; i < 3; i++) begin
                     if (shr[i] > wmin) begin
                        cut = deficit * cnt[i] / donors;
                        shr[i] = (cut > shr[i]) ? 0 : shr[i] - cut;
                     end
                  end
               end
            end
            for (int i = 0; i < 3; i++) begin
               e = shr[i] * eff;
               g[i] = e >> 16;
               frc[i] = e & 'hFFFF;
               used += g[i];
            end
            // exchange sort by falling fraction
            for (int i = 0; i < 2; i++) begin
               for (int j = i + 1; j < 3; j++) begin
                  if (frc[ord[j]] > frc[ord[i]]) begin
                     t = ord[i]; ord[i] = ord[j]; ord[j] = t;
                  end
               end
            end
            left = (eff > used) ? eff - used : 0;
            for (int i = 0; i < 3; i++) g[ord[i]] += left / 3 + ((i < left % 3) ? 1 : 0);
            for (int i = 0; i < 3; i++) g[i] = clamp(g[i]);
         end
         r.ga = g[0][7:0]; r.gb = g[1][7:0]; r.gc = g[2][7:0];
         pending.push_back(r);
      endfunction

      task check_beat(logic [7:0] ga, logic [7:0] gb, logic [7:0] gc);
         green_set_type x;
         checked++;
         if (pending.size() == 0) begin
            report_error($sformatf("unexpected rsp beat %0d/%0d/%0d", ga, gb, gc));
            return;
         end
         x = pending.pop_front();
         if (ga !== x.ga) report_error($sformatf("green_a %0d want %0d", ga, x.ga));
         if (gb !== x.gb) report_error($sformatf("green_b %0d want %0d", gb, x.gb));
         if (gc !== x.gc) report_error($sformatf("green_c %0d want %0d", gc, x.gc));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [9:0] req_count_a = 0, req_count_b = 0, req_count_c = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [7:0] rsp_green_a, rsp_green_b, rsp_green_c;
   logic csr_write_en = 0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CYCLE_TIME;
   logic [CSR_DATA_W-1:0] csr_data = 0;

   green_scoreboard sb;
   longint cycles = 0;
   int sent = 0;

   localparam longint CYCLE_LIMIT = 2_000_000;

   traffic_green_time_splitter #(.COUNT_WIDTH(10)) i_dut (.*);

   always #5 clock = ~clock;

   // count cycles and give up at the limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // check each accepted rsp beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_beat(rsp_green_a, rsp_green_b, rsp_green_c);
   end

   // stall the rsp channel at random
   initial begin
      int waitn;
      forever begin
         @(negedge clock);
         if (rsp_valid && !rsp_stall) begin
            waitn = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            rsp_stall <= (waitn != 0);
            repeat (waitn) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_data <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_write_en <= 0;
   endtask

   // drive one req beat, after a random gap when gaps is set
   task automatic send_counts(logic [9:0] a, logic [9:0] b, logic [9:0] c, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 6) : 0;
      repeat (gap + 1) @(negedge clock);
      req_valid <= 1;
      req_count_a <= a;
      req_count_b <= b;
      req_count_c <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_counts(a, b, c);
      sent++;
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic setup(int ct, int lt, int mn, int mx, int sc);
      drain();
      write_csr(CSR_CYCLE_TIME, 16'(ct));
      write_csr(CSR_LOST_TIME, 16'(lt));
      write_csr(CSR_MIN_GREEN, 16'(mn));
      write_csr(CSR_MAX_GREEN, 16'(mx));
      write_csr(CSR_SHARE_SCALE, 16'(sc));
   endtask

   // mostly counts over the full range, sometimes zeros, small counts and the maximum
   function automatic logic [9:0] pick_count();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 10'h3FF;
         2: return 10'($urandom_range(0, 7));
         default: return 10'($urandom_range(0, 1023));
      endcase
   endfunction

   initial begin
      sb = new();
      sb.restore();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // first cycle after reset, then zero total and extremes at reset config
      send_counts(100, 200, 300, 0);
      send_counts(0, 0, 0, 0);
      send_counts(10'h3FF, 10'h3FF, 10'h3FF, 1);
      send_counts(10'h3FF, 0, 0, 1);
      send_counts(1, 1000, 0, 1);
      send_counts(10'h155, 10'h2AA, 10'h155, 1);
      send_counts(1, 1, 10'h3FF, 1);

      // short cycle: effective time saturates at zero
      setup(20, 15, 5, 60, 'hFFFF);
      send_counts(5, 6, 7, 1);
      send_counts(0, 0, 0, 1);
      // inverted clamp
      setup(255, 0, 200, 30, 58982);
      send_counts(3, 500, 9, 1);
      send_counts(0, 0, 0, 1);
      // big minimum weight, no donors
      setup(40, 3, 255, 255, 0);
      send_counts(7, 8, 9, 1);
      send_counts(1023, 1, 0, 1);
      // zero clamps and full scale
      setup(255, 15, 0, 0, 'hFFFF);
      send_counts(200, 100, 50, 1);
      setup(255, 0, 0, 255, 'hFFFF);
      send_counts(1023, 511, 2, 1);
      send_counts(10'h2AA, 10'h155, 10'h3FF, 1);

      // random phases, most with fresh random settings, some with the reset settings
      for (int ph = 0; ph < 11; ph++) begin
         if (ph != 0) begin
            if (ph % 4 == 0)
               setup(120, 4, 10, 80, 58982);
            else
               setup($urandom_range(20, 255), $urandom_range(0, 15),
                     $urandom_range(0, 40), $urandom_range(30, 255),
                     $urandom_range(0, 65535));
         end
         for (int k = 0; k < 50; k++) begin
            // pause until everything is back now and then
            if (k == 25) while (sb.pending.size() != 0) @(negedge clock);
            send_counts(pick_count(), pick_count(), pick_count(), (ph % 3) != 2);
         end
      end

      drain();
      $display("sent %0d count beats over 16 register settings, %0d results checked",
               sent, sb.checked);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
